@@ hw/rtl/softswitch_bank_mapper_unit_assert.svh @@
// assertion macros for the soft switch bank mapper
// expect clock and reset in the using scope; compiled out when SYNTHESIS is defined
`ifndef SOFTSWITCH_BANK_MAPPER_UNIT_ASSERT_SVH
`define SOFTSWITCH_BANK_MAPPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// implication that must hold on every clock edge outside reset
`define SBM_ASSERT_HOLDS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbm: same-cycle check failed");

// implication whose consequence is checked in the next cycle
`define SBM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbm: next-cycle check failed");

`else

`define SBM_ASSERT_HOLDS(lbl, ante, cons)
`define SBM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/sbm_pkg.sv @@
// types and constants for the soft switch bank mapper
// no dependencies
`default_nettype none

package sbm_pkg;

   localparam int FLAG_W     = 18;
   localparam int FLAG_IDX_W = 5;

   typedef logic [FLAG_W-1:0]     flags_type;
   typedef logic [FLAG_IDX_W-1:0] flag_idx_type;

   // flag bit positions; the first sixteen also follow status select order
   localparam flag_idx_type FLAG_PAGE2   = 5'd0;
   localparam flag_idx_type FLAG_TEXT    = 5'd1;
   localparam flag_idx_type FLAG_MIXED   = 5'd2;
   localparam flag_idx_type FLAG_HIRES   = 5'd3;
   localparam flag_idx_type FLAG_BANK2   = 5'd4;
   localparam flag_idx_type FLAG_LCRAM   = 5'd5;
   localparam flag_idx_type FLAG_80STORE = 5'd6;
   localparam flag_idx_type FLAG_RAMRD   = 5'd7;
   localparam flag_idx_type FLAG_RAMWRT  = 5'd8;
   localparam flag_idx_type FLAG_ALTZP   = 5'd9;
   localparam flag_idx_type FLAG_80COL   = 5'd10;
   localparam flag_idx_type FLAG_ALTCHAR = 5'd11;
   localparam flag_idx_type FLAG_IOUDIS  = 5'd12;
   localparam flag_idx_type FLAG_DHIRES  = 5'd13;
   localparam flag_idx_type FLAG_C3ROM   = 5'd14;
   localparam flag_idx_type FLAG_CXROM   = 5'd15;
   localparam flag_idx_type FLAG_PREWR   = 5'd16;
   localparam flag_idx_type FLAG_LCWRT   = 5'd17;

   // switch codes
   localparam logic [5:0] CODE_VIDEO_LAST = 6'd7;
   localparam logic [5:0] CODE_LC_FIRST   = 6'd8;
   localparam logic [5:0] CODE_LC_LAST    = 6'd15;
   localparam logic [5:0] CODE_PAIR_FIRST = 6'd16;
   localparam logic [5:0] CODE_PAIR_LAST  = 6'd35;
   localparam logic [5:0] CODE_STATUS     = 6'd36;

   localparam logic [4:0] STATUS_SEL_COUNT = 5'd16;
   localparam logic [7:0] STATUS_SET_BYTE  = 8'h80;

   // flag driven by each off/on pair
   function automatic flag_idx_type pair_flag_idx(input logic [3:0] pair);
      flag_idx_type idx;
      case (pair)
         4'd0:    idx = FLAG_PAGE2;
         4'd1:    idx = FLAG_HIRES;
         4'd2:    idx = FLAG_TEXT;
         4'd3:    idx = FLAG_MIXED;
         4'd4:    idx = FLAG_80STORE;
         4'd5:    idx = FLAG_RAMRD;
         4'd6:    idx = FLAG_RAMWRT;
         4'd7:    idx = FLAG_ALTZP;
         4'd8:    idx = FLAG_80COL;
         4'd9:    idx = FLAG_ALTCHAR;
         4'd10:   idx = FLAG_IOUDIS;
         4'd11:   idx = FLAG_DHIRES;
         4'd12:   idx = FLAG_C3ROM;
         4'd13:   idx = FLAG_CXROM;
         default: idx = FLAG_PAGE2;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/softswitch_bank_mapper_unit.sv @@
// soft switch bank mapper: beats pass the input register, then the result
// register; one beat per cycle unless rsp_ready stalls; the flag register is
// read and updated once per beat in the decode stage, which sets the rate
// synchronous active-high reset clears all mode flags (rom / main / protected)
// and empties both pipeline registers
// depends on sbm_pkg and softswitch_bank_mapper_unit_assert.svh
`default_nettype none

`include "softswitch_bank_mapper_unit_assert.svh"

module softswitch_bank_mapper_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [5:0] req_type,
   input  wire logic [4:0] req_status_select,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic [2:0]      rsp_d000_read_src,
   output logic [2:0]      rsp_d000_write_dst,
   output logic [1:0]      rsp_e000_read_src,
   output logic [1:0]      rsp_e000_write_dst,
   output logic [6:0]      rsp_aux_select_map,
   output logic [1:0]      rsp_rom_select_map,
   output logic            rsp_display_page2,
   output logic            rsp_redraw_request
);

   import sbm_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [5:0] s1_type_ff;
   logic [4:0] s1_sel_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] read_data_ff, read_data_in;
   logic [2:0] d000_rd_ff, d000_rd_in;
   logic [2:0] d000_wr_ff, d000_wr_in;
   logic [1:0] e000_rd_ff, e000_rd_in;
   logic [1:0] e000_wr_ff, e000_wr_in;
   logic [6:0] aux_sel_ff, aux_sel_in;
   logic [1:0] rom_sel_ff, rom_sel_in;
   logic       page2_ff, page2_in;
   logic       redraw_ff, redraw_in;

   flags_type  flags_ff, flags_in;

   logic         advance;
   logic         is_pair, is_lc, is_status;
   logic [5:0]   pair_rel;
   logic [3:0]   pair;
   flag_idx_type pidx;
   logic [2:0]   lc_n;
   logic         status_bit;
   logic [1:0]   bank;
   logic         az, st, p2, rr, rw, hgr80, cx;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign is_pair   = (s1_type_ff <= CODE_VIDEO_LAST) ||
                      ((s1_type_ff >= CODE_PAIR_FIRST) && (s1_type_ff <= CODE_PAIR_LAST));
   assign is_lc     = (s1_type_ff >= CODE_LC_FIRST) && (s1_type_ff <= CODE_LC_LAST);
   assign is_status = (s1_type_ff == CODE_STATUS);
   assign pair_rel  = s1_type_ff - CODE_PAIR_FIRST;
   assign pair      = (s1_type_ff <= CODE_VIDEO_LAST) ? {2'b00, s1_type_ff[2:1]}
                                                       : pair_rel[4:1] + 4'd4;
   assign pidx      = pair_flag_idx(pair);
   assign lc_n      = s1_type_ff[2:0];

   always_comb begin
      flags_in  = flags_ff;
      redraw_in = 1'b0;
      if (is_pair) begin
         flags_in[pidx] = s1_type_ff[0];
         if (flags_ff[pidx] != s1_type_ff[0]) begin
            if (pidx == FLAG_HIRES || pidx == FLAG_TEXT || pidx == FLAG_MIXED ||
                pidx == FLAG_DHIRES || pidx == FLAG_ALTCHAR) begin
               redraw_in = 1'b1;
            end
            if (pidx == FLAG_80COL && (flags_ff[FLAG_TEXT] || flags_ff[FLAG_MIXED] ||
                                       flags_ff[FLAG_DHIRES])) begin
               redraw_in = 1'b1;
            end
         end
      end else if (is_lc) begin
         // two odd accesses with no even one between enable writes, an even one disarms and disables writes
         if (lc_n[0]) begin
            if (flags_ff[FLAG_PREWR]) begin
               flags_in[FLAG_LCWRT] = 1'b1;
            end
            flags_in[FLAG_PREWR] = 1'b1;
         end else begin
            flags_in[FLAG_PREWR] = 1'b0;
            flags_in[FLAG_LCWRT] = 1'b0;
         end
         flags_in[FLAG_LCRAM] = (lc_n[1:0] == 2'd0) || (lc_n[1:0] == 2'd3);
         flags_in[FLAG_BANK2] = !lc_n[2];
      end
   end

   // status read; c3rom reads reversed, selects of sixteen and above read zero
   always_comb begin
      status_bit = flags_ff[s1_sel_ff[3:0]];
      if (s1_sel_ff[3:0] == FLAG_C3ROM[3:0]) begin
         status_bit = !status_bit;
      end
      read_data_in = (is_status && (s1_sel_ff < STATUS_SEL_COUNT) && status_bit)
                     ? STATUS_SET_BYTE : 8'h00;
   end

   // selects from the updated flags
   always_comb begin
      bank  = flags_in[FLAG_BANK2] ? 2'd2 : 2'd1;
      az    = flags_in[FLAG_ALTZP];
      st    = flags_in[FLAG_80STORE];
      p2    = flags_in[FLAG_PAGE2];
      rr    = flags_in[FLAG_RAMRD];
      rw    = flags_in[FLAG_RAMWRT];
      hgr80 = st && flags_in[FLAG_HIRES];
      cx    = flags_in[FLAG_CXROM];

      d000_rd_in = flags_in[FLAG_LCRAM] ? ({1'b0, bank} + {1'b0, az, 1'b0}) : 3'd0;
      d000_wr_in = flags_in[FLAG_LCWRT] ? ({1'b0, bank} + {1'b0, az, 1'b0}) : 3'd0;
      e000_rd_in = flags_in[FLAG_LCRAM] ? (2'd1 + {1'b0, az}) : 2'd0;
      e000_wr_in = flags_in[FLAG_LCWRT] ? (2'd1 + {1'b0, az}) : 2'd0;
      aux_sel_in = {az,
                    hgr80 ? p2 : rw,
                    hgr80 ? p2 : rr,
                    st ? p2 : rw,
                    st ? p2 : rr,
                    rw,
                    rr};
      rom_sel_in = {cx || flags_in[FLAG_C3ROM], cx};
      page2_in   = p2 && !st;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff <= req_type;
         s1_sel_ff  <= req_status_select;
      end
      if (advance) begin
         read_data_ff <= read_data_in;
         d000_rd_ff   <= d000_rd_in;
         d000_wr_ff   <= d000_wr_in;
         e000_rd_ff   <= e000_rd_in;
         e000_wr_ff   <= e000_wr_in;
         aux_sel_ff   <= aux_sel_in;
         rom_sel_ff   <= rom_sel_in;
         page2_ff     <= page2_in;
         redraw_ff    <= redraw_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_d000_read_src  = d000_rd_ff;
   assign rsp_d000_write_dst = d000_wr_ff;
   assign rsp_e000_read_src  = e000_rd_ff;
   assign rsp_e000_write_dst = e000_wr_ff;
   assign rsp_aux_select_map = aux_sel_ff;
   assign rsp_rom_select_map = rom_sel_ff;
   assign rsp_display_page2  = page2_ff;
   assign rsp_redraw_request = redraw_ff;

   // write enable only ever rises off an armed prewrite
   `SBM_ASSERT_HOLDS(a_lcwrt_armed, $rose(flags_ff[FLAG_LCWRT]), $past(flags_ff[FLAG_PREWR]))
   // a beat leaving the input register always lands in the result register
   `SBM_ASSERT_NEXT(a_advance_lands, advance, rsp_valid_ff)
   // d000 and e000 regions switch between rom and ram together
   `SBM_ASSERT_HOLDS(a_region_agree, rsp_valid_ff, (d000_rd_ff == 3'd0) == (e000_rd_ff == 2'd0))

endmodule

`default_nettype wire
